/* rtl/core/cobs_crc_frame_receiver_core_macros.svh */
// ----------------------------------------------------------------------------
// COBS CRC frame receiver assertion macros
// Assertion helpers that expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef COBS_CRC_FRAME_RECEIVER_CORE_MACROS_SVH
`define COBS_CRC_FRAME_RECEIVER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CCFR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ccfr assertion failed");
`define CCFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ccfr assertion failed");
`else
`define CCFR_ASSERT_SAME(label, clk, rst, ante, cons)
`define CCFR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/ccfr_pkg.sv */
// ----------------------------------------------------------------------------
// COBS CRC frame receiver package
// Shared constants, types and the CRC-16-CCITT byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package ccfr_pkg;

   localparam int unsigned MAX_FRAME    = 4096;
   localparam int unsigned HEADER_BYTES = 16;
   localparam int unsigned COUNT_W      = $clog2(MAX_FRAME + 1);
   localparam int unsigned HDR_IDX_W    = $clog2(HEADER_BYTES);

   localparam logic [31:0] MAGIC_RESET   = 32'h544C_4D31;
   localparam logic [7:0]  VERSION_RESET = 8'h01;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [7:0]  CODE_FULL     = 8'hFF;
   localparam logic [7:0]  TYPE_DATA     = 8'd1;
   localparam logic [7:0]  TYPE_DEFINE   = 8'd2;

   localparam int unsigned CSR_ADDR_W = 3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MAGIC   = 3'd0,
      CSR_VERSION = 3'd4
   } csr_addr_type;

   typedef enum logic [2:0] {
      FRAME_OK      = 3'd0,
      FRAME_OVERRUN = 3'd1,
      FRAME_SHORT   = 3'd2,
      FRAME_CRC     = 3'd3,
      FRAME_HEADER  = 3'd4,
      FRAME_LENGTH  = 3'd5
   } frame_status_type;

   typedef enum logic {
      KIND_BYTE    = 1'b0,
      KIND_VERDICT = 1'b1
   } result_kind_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
      logic [15:0] crc;
      crc = crc_in ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (crc[15]) begin
            crc = {crc[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc = {crc[14:0], 1'b0};
         end
      end
      return crc;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/ccfr_channels.sv */
// ----------------------------------------------------------------------------
// COBS CRC frame receiver channels
// Valid/ready interfaces for the raw byte input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface ccfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  data_byte;
   logic [11:0] byte_index;
   logic [2:0]  frame_status;
   logic [7:0]  message_type;
   logic [15:0] payload_length;
   logic [31:0] sequence_number;
   logic [31:0] sender_time;
   logic [31:0] good_total;
   logic [31:0] bad_total;

   modport source (output valid, output result_kind, output data_byte, output byte_index,
                   output frame_status, output message_type, output payload_length,
                   output sequence_number, output sender_time, output good_total,
                   output bad_total, input ready);
   modport sink (input valid, input result_kind, input data_byte, input byte_index,
                 input frame_status, input message_type, input payload_length,
                 input sequence_number, input sender_time, input good_total,
                 input bad_total, output ready);
endinterface

`default_nettype wire

/* rtl/core/cobs_crc_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// COBS CRC frame receiver core
// Decodes a COBS byte stream, checks CRC and header, and reports each frame.
// ----------------------------------------------------------------------------
// The block takes one raw link word per cycle while its input is ready and
// delivers any decoded byte or frame verdict from its result register in the
// next cycle. The input is ready whenever that register is empty or being
// taken in the same cycle, so an unstalled stream runs at one word per cycle
// with no gaps; the CRC update and the verdict compare sit in that single stage.
`default_nettype none

`include "cobs_crc_frame_receiver_core_macros.svh"

module cobs_crc_frame_receiver_core
   import ccfr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   ccfr_req_if.sink                   req_if,
   ccfr_rsp_if.source                 rsp_if,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   logic [31:0]        magic_ff;
   logic [7:0]         version_ff;
   logic               csr_write;

   logic [COUNT_W-1:0] raw_count_ff, raw_count_in;
   logic [7:0]         block_left_ff, block_left_in;
   logic               zero_pending_ff, zero_pending_in;
   logic [COUNT_W-1:0] decoded_count_ff, decoded_count_in;
   logic [15:0]        crc_ff, crc_in;
   logic [15:0]        tail_ff, tail_in;
   logic [7:0]         header_ff [HEADER_BYTES];
   logic [7:0]         header_in [HEADER_BYTES];
   logic [31:0]        good_ff, good_in;
   logic [31:0]        bad_ff, bad_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               kind_ff, kind_in;
   logic [7:0]         data_ff, data_in;
   logic [11:0]        index_ff, index_in;
   logic [2:0]         status_ff, status_in;
   logic [7:0]         type_ff, type_in;
   logic [15:0]        plen_ff, plen_in;
   logic [31:0]        seq_ff, seq_in;
   logic [31:0]        time_ff, time_in;

   logic               accept;
   logic               emit;
   logic [7:0]         emit_value;
   logic               frame_clear;
   frame_status_type   status;
   logic [15:0]        hdr_plen;
   logic [7:0]         hdr_type;
   logic [31:0]        hdr_magic;
   logic [17:0]        expected_count;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = paddr[2] ? {24'd0, version_ff} : magic_ff;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign hdr_magic      = {header_ff[3], header_ff[2], header_ff[1], header_ff[0]};
   assign hdr_type       = header_ff[5];
   assign hdr_plen       = {header_ff[7], header_ff[6]};
   assign expected_count = 18'(HEADER_BYTES) + 18'(hdr_plen) + 18'd2;

   always_comb begin
      if (block_left_ff != 8'd0) begin
         status = FRAME_OVERRUN;
      end else if (decoded_count_ff < COUNT_W'(HEADER_BYTES + 2)) begin
         status = FRAME_SHORT;
      end else if (tail_ff != crc_ff) begin
         status = FRAME_CRC;
      end else if (hdr_magic != magic_ff || header_ff[4] != version_ff ||
                   (hdr_type != TYPE_DATA && hdr_type != TYPE_DEFINE)) begin
         status = FRAME_HEADER;
      end else if (expected_count != 18'(decoded_count_ff)) begin
         status = FRAME_LENGTH;
      end else begin
         status = FRAME_OK;
      end
   end

   always_comb begin
      raw_count_in     = raw_count_ff;
      block_left_in    = block_left_ff;
      zero_pending_in  = zero_pending_ff;
      decoded_count_in = decoded_count_ff;
      crc_in           = crc_ff;
      tail_in          = tail_ff;
      header_in        = header_ff;
      good_in          = good_ff;
      bad_in           = bad_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_if.ready;
      kind_in          = kind_ff;
      data_in          = data_ff;
      index_in         = index_ff;
      status_in        = status_ff;
      type_in          = type_ff;
      plen_in          = plen_ff;
      seq_in           = seq_ff;
      time_in          = time_ff;
      emit             = 1'b0;
      emit_value       = 8'd0;
      frame_clear      = 1'b0;

      if (accept) begin
         if (req_if.rx_byte == 8'd0) begin
            if (raw_count_ff != '0) begin
               if (status == FRAME_OK) begin
                  good_in = good_ff + 32'd1;
               end else begin
                  bad_in = bad_ff + 32'd1;
               end
               rsp_valid_in = 1'b1;
               kind_in      = KIND_VERDICT;
               data_in      = 8'd0;
               index_in     = 12'd0;
               status_in    = status;
               type_in      = hdr_type;
               plen_in      = hdr_plen;
               seq_in       = {header_ff[11], header_ff[10], header_ff[9], header_ff[8]};
               time_in      = {header_ff[15], header_ff[14], header_ff[13], header_ff[12]};
               frame_clear  = 1'b1;
            end
         end else if (raw_count_ff >= COUNT_W'(MAX_FRAME)) begin
            frame_clear = 1'b1;
         end else begin
            raw_count_in = raw_count_ff + COUNT_W'(1);
            if (block_left_ff == 8'd0) begin
               block_left_in   = req_if.rx_byte - 8'd1;
               zero_pending_in = req_if.rx_byte != CODE_FULL;
               emit            = zero_pending_ff;
               emit_value      = 8'd0;
            end else begin
               block_left_in = block_left_ff - 8'd1;
               emit          = 1'b1;
               emit_value    = req_if.rx_byte;
            end
         end
      end

      if (emit) begin
         for (int i = 0; i < HEADER_BYTES; i++) begin
            if (decoded_count_ff < COUNT_W'(HEADER_BYTES) &&
                decoded_count_ff[HDR_IDX_W-1:0] == HDR_IDX_W'(i)) begin
               header_in[i] = emit_value;
            end
         end
         if (decoded_count_ff >= COUNT_W'(2)) begin
            crc_in = crc_feed(crc_ff, tail_ff[7:0]);
         end
         tail_in          = {emit_value, tail_ff[15:8]};
         decoded_count_in = decoded_count_ff + COUNT_W'(1);
         rsp_valid_in     = 1'b1;
         kind_in          = KIND_BYTE;
         data_in          = emit_value;
         index_in         = decoded_count_ff[11:0];
         status_in        = FRAME_OK;
         type_in          = 8'd0;
         plen_in          = 16'd0;
         seq_in           = 32'd0;
         time_in          = 32'd0;
      end

      if (frame_clear) begin
         raw_count_in     = '0;
         block_left_in    = 8'd0;
         zero_pending_in  = 1'b0;
         decoded_count_in = '0;
         crc_in           = CRC_INIT;
         tail_in          = 16'd0;
         for (int i = 0; i < HEADER_BYTES; i++) begin
            header_in[i] = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff         <= MAGIC_RESET;
         version_ff       <= VERSION_RESET;
         raw_count_ff     <= '0;
         block_left_ff    <= 8'd0;
         zero_pending_ff  <= 1'b0;
         decoded_count_ff <= '0;
         crc_ff           <= CRC_INIT;
         tail_ff          <= 16'd0;
         good_ff          <= 32'd0;
         bad_ff           <= 32'd0;
         rsp_valid_ff     <= 1'b0;
         for (int i = 0; i < HEADER_BYTES; i++) begin
            header_ff[i] <= 8'd0;
         end
      end else begin
         if (csr_write && paddr[2] == CSR_MAGIC[2]) begin
            magic_ff <= pwdata;
         end
         if (csr_write && paddr[2] == CSR_VERSION[2]) begin
            version_ff <= pwdata[7:0];
         end
         raw_count_ff     <= raw_count_in;
         block_left_ff    <= block_left_in;
         zero_pending_ff  <= zero_pending_in;
         decoded_count_ff <= decoded_count_in;
         crc_ff           <= crc_in;
         tail_ff          <= tail_in;
         good_ff          <= good_in;
         bad_ff           <= bad_in;
         rsp_valid_ff     <= rsp_valid_in;
         header_ff        <= header_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      data_ff   <= data_in;
      index_ff  <= index_in;
      status_ff <= status_in;
      type_ff   <= type_in;
      plen_ff   <= plen_in;
      seq_ff    <= seq_in;
      time_ff   <= time_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.result_kind     = kind_ff;
   assign rsp_if.data_byte       = data_ff;
   assign rsp_if.byte_index      = index_ff;
   assign rsp_if.frame_status    = status_ff;
   assign rsp_if.message_type    = type_ff;
   assign rsp_if.payload_length  = plen_ff;
   assign rsp_if.sequence_number = seq_ff;
   assign rsp_if.sender_time     = time_ff;
   assign rsp_if.good_total      = good_ff;
   assign rsp_if.bad_total       = bad_ff;

   `CCFR_ASSERT_SAME(a_decoded_within_raw, clock, reset, 1'b1, decoded_count_ff <= raw_count_ff)
   `CCFR_ASSERT_SAME(a_raw_within_max, clock, reset, 1'b1, raw_count_ff <= COUNT_W'(MAX_FRAME))
   `CCFR_ASSERT_NEXT(a_verdict_follows_delimiter, clock, reset, accept && req_if.rx_byte == 8'd0 && raw_count_ff != '0, rsp_valid_ff && kind_ff == KIND_VERDICT && good_ff + bad_ff == $past(good_ff) + $past(bad_ff) + 32'd1)
   `CCFR_ASSERT_NEXT(a_oversize_clears_frame, clock, reset, accept && req_if.rx_byte != 8'd0 && raw_count_ff >= COUNT_W'(MAX_FRAME), raw_count_ff == '0 && decoded_count_ff == '0)

endmodule

`default_nettype wire
